### rtl/iirl_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iirl_pkg: shared types and constants of the indexed insert/remove list
// Command and status codes, transaction field widths, and the control word
// that the list controller broadcasts to every storage cell.
// ----------------------------------------------------------------------------
package iirl_pkg;

	// Default sizing of the list
	localparam int IIRL_DEPTH      = 16;
	localparam int IIRL_VALUE_BITS = 32;
	localparam int IIRL_DEPTH_MAX  = 1024;

	// Transaction field widths
	localparam int FIELD_CMD_W    = 3;
	localparam int FIELD_INDEX_W  = 5;
	localparam int FIELD_VALUE_W  = 32;
	localparam int FIELD_STATUS_W = 2;
	localparam int FIELD_COUNT_W  = 5;

	// Position width that covers every supported depth, count included
	localparam int CTL_IDX_W = $clog2(IIRL_DEPTH_MAX + 1);

	// Command codes
	typedef enum logic [FIELD_CMD_W-1:0] {
		CMD_GET = 3'd0,
		CMD_SET = 3'd1,
		CMD_INS = 3'd2,
		CMD_REM = 3'd3,
		CMD_APP = 3'd4
	} cmd_t;

	// Status codes
	typedef enum logic [FIELD_STATUS_W-1:0] {
		ST_OK    = 2'd0,
		ST_RANGE = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	// Cell operations
	typedef enum logic [1:0] {
		OP_HOLD,
		OP_SET,
		OP_INS,
		OP_REM
	} cell_op_t;

	// Control word broadcast along the cell row
	typedef struct packed {
		cell_op_t               op;
		logic [CTL_IDX_W-1:0]   idx;
		logic [FIELD_VALUE_W-1:0] value;
	} cell_ctl_t;

endpackage

### rtl/iirl_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iirl_if: command and response channels of the list
// Valid/ready channels; a transaction moves at a clock edge where both are high.
// ----------------------------------------------------------------------------
interface iirl_req_if;
	import iirl_pkg::*;

	logic                     valid;
	logic                     ready;
	logic [FIELD_CMD_W-1:0]   cmd;
	logic [FIELD_INDEX_W-1:0] index;
	logic [FIELD_VALUE_W-1:0] value;

	modport source (output valid, cmd, index, value, input ready);
	modport sink (input valid, cmd, index, value, output ready);
endinterface

interface iirl_rsp_if;
	import iirl_pkg::*;

	logic                      valid;
	logic                      ready;
	logic [FIELD_STATUS_W-1:0] status;
	logic [FIELD_VALUE_W-1:0]  read_value;
	logic [FIELD_COUNT_W-1:0]  count;
	logic                      empty_res;

	modport source (output valid, status, read_value, count, empty_res, input ready);
	modport sink (input valid, status, read_value, count, empty_res, output ready);
endinterface

### rtl/indexed_insert_remove_list.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// indexed_insert_remove_list: ordered list of element handles
// Get, set, insert at index, remove at index and append over a row of cells.
// ----------------------------------------------------------------------------
// The list takes one command transaction per clock cycle while responses are
// taken, and answers the cycle after acceptance from an output register; a new
// command is accepted whenever that register is empty or is being taken in
// the same cycle, so back-to-back commands run at one per cycle. The entries
// sit in a row of DEPTH cells: a single broadcast control word moves every
// entry above an insert point up one cell, or every entry above a removal
// point down one cell, in the cycle of acceptance. Errors (index out of range,
// insert or append on a full list) leave the list unchanged. Entries have no
// reset; only the count and response valid are cleared, so no clearing pass.
// ----------------------------------------------------------------------------
module indexed_insert_remove_list
	import iirl_pkg::*;
#(
	parameter int DEPTH      = IIRL_DEPTH,
	parameter int VALUE_BITS = IIRL_VALUE_BITS
) (
	input  logic     clk,
	input  logic     arst_n,
	iirl_req_if.sink   req,
	iirl_rsp_if.source rsp
);

	localparam int CNT_W  = $clog2(DEPTH + 1);
	localparam int ADDR_W = $clog2(DEPTH);
	localparam logic [CTL_IDX_W-1:0] DEPTH_C = CTL_IDX_W'(DEPTH);

	logic [CNT_W-1:0]          count_q;
	logic [CNT_W-1:0]          count_nxt;
	logic                      out_valid_q;
	status_t                   status_q;
	logic [FIELD_VALUE_W-1:0]  read_q;
	logic [FIELD_COUNT_W-1:0]  count_out_q;
	logic                      empty_q;

	logic                      accept;
	cell_ctl_t                 ctl;
	status_t                   status_nxt;
	logic [FIELD_VALUE_W-1:0]  read_nxt;
	logic [CTL_IDX_W-1:0]      idx_w;
	logic [CTL_IDX_W-1:0]      cnt_w;
	logic [CTL_IDX_W-1:0]      ins_pos;
	logic [FIELD_VALUE_W-1:0]  sel_value;
	logic                      in_range;

	logic [VALUE_BITS-1:0] cell_data  [DEPTH];
	logic [VALUE_BITS-1:0] left_data  [DEPTH];
	logic [VALUE_BITS-1:0] right_data [DEPTH];

	assign req.ready = !out_valid_q || rsp.ready;
	assign accept    = req.valid && req.ready;

	assign idx_w     = CTL_IDX_W'(req.index);
	assign cnt_w     = CTL_IDX_W'(count_q);
	assign in_range  = idx_w < cnt_w;
	assign sel_value = FIELD_VALUE_W'(cell_data[idx_w[ADDR_W-1:0]]);
	assign ins_pos   = (req.cmd == CMD_APP) ? cnt_w : idx_w;

	// Decode the command into a cell operation, status and read data
	always_comb begin
		ctl.op     = OP_HOLD;
		ctl.idx    = idx_w;
		ctl.value  = req.value;
		status_nxt = ST_OK;
		read_nxt   = '0;
		count_nxt  = count_q;
		unique case (req.cmd)
			CMD_GET: begin
				if (in_range) read_nxt = sel_value;
				else status_nxt = ST_RANGE;
			end
			CMD_SET: begin
				if (in_range) ctl.op = OP_SET;
				else status_nxt = ST_RANGE;
			end
			CMD_INS, CMD_APP: begin
				ctl.idx = ins_pos;
				if (ins_pos > cnt_w) begin
					status_nxt = ST_RANGE;
				end else if (cnt_w >= DEPTH_C) begin
					status_nxt = ST_FULL;
				end else begin
					ctl.op    = OP_INS;
					count_nxt = count_q + CNT_W'(1);
				end
			end
			CMD_REM: begin
				if (in_range) begin
					ctl.op    = OP_REM;
					read_nxt  = sel_value;
					count_nxt = count_q - CNT_W'(1);
				end else begin
					status_nxt = ST_RANGE;
				end
			end
			default: begin
				status_nxt = ST_OK;
			end
		endcase
		if (!accept) ctl.op = OP_HOLD;
	end

	// Row of storage cells with neighbor links
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		if (i == 0) begin : g_first
			assign left_data[i] = '0;
		end else begin : g_left
			assign left_data[i] = cell_data[i-1];
		end
		if (i == DEPTH - 1) begin : g_last
			assign right_data[i] = '0;
		end else begin : g_right
			assign right_data[i] = cell_data[i+1];
		end

		iirl_cell #(
			.POS        (i),
			.VALUE_BITS (VALUE_BITS)
		) u_cell (
			.clk        (clk),
			.ctl        (ctl),
			.left_data  (left_data[i]),
			.right_data (right_data[i]),
			.data       (cell_data[i])
		);
	end

	// Advance the entry count and the response valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				count_q     <= count_nxt;
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Capture the response payload
	always_ff @(posedge clk) begin
		if (accept) begin
			status_q    <= status_nxt;
			read_q      <= read_nxt;
			count_out_q <= FIELD_COUNT_W'(count_nxt);
			empty_q     <= (count_nxt == '0);
		end
	end

	assign rsp.valid      = out_valid_q;
	assign rsp.status     = status_q;
	assign rsp.read_value = read_q;
	assign rsp.count      = count_out_q;
	assign rsp.empty_res  = empty_q;

endmodule

### rtl/iirl_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iirl_cell: one storage position of the list
// Holds one entry; on a broadcast command it loads the new value, takes the
// entry of its lower neighbor (insert) or of its upper neighbor (remove).
// ----------------------------------------------------------------------------
module iirl_cell
	import iirl_pkg::*;
#(
	parameter int POS        = 0,
	parameter int VALUE_BITS = IIRL_VALUE_BITS
) (
	input  logic                  clk,
	input  cell_ctl_t             ctl,
	input  logic [VALUE_BITS-1:0] left_data,
	input  logic [VALUE_BITS-1:0] right_data,
	output logic [VALUE_BITS-1:0] data
);

	localparam logic [CTL_IDX_W-1:0] MY_POS = CTL_IDX_W'(POS);

	logic [VALUE_BITS-1:0] data_q;
	logic [VALUE_BITS-1:0] data_nxt;
	logic [VALUE_BITS-1:0] new_value;

	assign new_value = VALUE_BITS'(ctl.value);

	// Select the next entry of this position
	always_comb begin
		data_nxt = data_q;
		unique case (ctl.op)
			OP_SET: begin
				if (ctl.idx == MY_POS) data_nxt = new_value;
			end
			OP_INS: begin
				if (ctl.idx == MY_POS) data_nxt = new_value;
				else if (MY_POS > ctl.idx) data_nxt = left_data;
			end
			OP_REM: begin
				if (MY_POS >= ctl.idx) data_nxt = right_data;
			end
			default: begin
				data_nxt = data_q;
			end
		endcase
	end

	// Hold the entry
	always_ff @(posedge clk) begin
		data_q <= data_nxt;
	end

	assign data = data_q;

endmodule

### rtl/iirl_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iirl_checker: port-level checks of the indexed insert/remove list
// Watches the response channel for consistency of status, count and data.
// ----------------------------------------------------------------------------
module iirl_checker
	import iirl_pkg::*;
(
	input logic                      clk,
	input logic                      arst_n,
	input logic                      rsp_valid,
	input logic                      rsp_ready,
	input logic [FIELD_STATUS_W-1:0] rsp_status,
	input logic [FIELD_VALUE_W-1:0]  rsp_read_value,
	input logic [FIELD_COUNT_W-1:0]  rsp_count,
	input logic                      rsp_empty_res
);

	logic [FIELD_COUNT_W-1:0] last_count_q;
	logic                     rsp_take;

	assign rsp_take = rsp_valid && rsp_ready;

	// Track the count of the last response transaction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_count_q <= '0;
		end else if (rsp_take) begin
			last_count_q <= rsp_count;
		end
	end

	// A pending response stays until taken
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid)
		else $error("response dropped while stalled");

	// Empty flag agrees with the count
	a_empty: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> rsp_empty_res == (rsp_count == '0))
		else $error("empty flag disagrees with count");

	// A failed command leaves the count and reads nothing
	a_err_state: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_take && rsp_status != ST_OK |->
			rsp_count == last_count_q && rsp_read_value == '0)
		else $error("failed command changed the list or returned data");

	// The count moves by at most one per command
	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_take |-> rsp_count == last_count_q
			|| rsp_count == last_count_q + FIELD_COUNT_W'(1)
			|| rsp_count == last_count_q - FIELD_COUNT_W'(1))
		else $error("count moved by more than one");

	// Only defined status codes appear
	a_status: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> rsp_status == ST_OK || rsp_status == ST_RANGE
			|| rsp_status == ST_FULL)
		else $error("undefined status code");

endmodule

bind indexed_insert_remove_list iirl_checker u_iirl_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.rsp_valid      (rsp.valid),
	.rsp_ready      (rsp.ready),
	.rsp_status     (rsp.status),
	.rsp_read_value (rsp.read_value),
	.rsp_count      (rsp.count),
	.rsp_empty_res  (rsp.empty_res)
);

### bench/tb_indexed_insert_remove_list.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_indexed_insert_remove_list: self-checking bench for the indexed list
// Drives get, set, insert, remove, append and unused command codes through
// the request channel and checks every response against a shadow copy of the
// list. A directed pass hits empty, full and range corners first, then a
// random pass alternates fill-heavy and drain-heavy stretches with random
// gaps and stalls on both channels.
// ----------------------------------------------------------------------------
module tb_indexed_insert_remove_list;
	import iirl_pkg::*;

	localparam int DEPTH            = IIRL_DEPTH;
	localparam int VALUE_BITS       = IIRL_VALUE_BITS;
	localparam int HALF_PERIOD      = 6;
	localparam int RESET_CYCLES     = 9;
	localparam int RANDOM_CMDS      = 450;
	localparam int INDEX_MAX        = (1 << FIELD_INDEX_W) - 1;
	localparam int LONG_HOLD_AT     = 120;
	localparam int LONG_HOLD_CYCLES = 60;
	localparam int SETTLE_CYCLES    = 8;
	localparam int TIMEOUT_NS       = 2_000_000;

	// Command codes the list treats as no operation
	localparam logic [FIELD_CMD_W-1:0] CMD_UNUSED_FIRST = 3'd5;
	localparam logic [FIELD_CMD_W-1:0] CMD_UNUSED_LAST  = 3'd7;

	typedef struct {
		logic [FIELD_CMD_W-1:0]   cmd;
		logic [FIELD_INDEX_W-1:0] index;
		logic [FIELD_VALUE_W-1:0] value;
		bit                       wait_idle;
	} list_cmd_t;

	typedef struct {
		status_t                  status;
		logic [FIELD_VALUE_W-1:0] read_value;
		logic [FIELD_COUNT_W-1:0] count;
		logic                     empty_res;
	} list_reply_t;

	logic clk;
	logic arst_n;

	iirl_req_if req_ch ();
	iirl_rsp_if rsp_ch ();

	indexed_insert_remove_list #(
		.DEPTH      (DEPTH),
		.VALUE_BITS (VALUE_BITS)
	) uut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	// Shadow copy of the list contents
	logic [FIELD_VALUE_W-1:0] shadow_entries [DEPTH];
	int                       shadow_count;

	list_cmd_t   pending_cmds [$];
	list_reply_t list_replies_due [$];
	list_cmd_t   drive_item;

	int  total_cmds;
	int  cmds_taken;
	int  replies_seen;
	int  mismatch_count;
	bit  cmd_taken_now;
	int  send_gap_left;
	int  rsp_stall_left;
	int  long_hold_left;
	bit  long_hold_done;
	int  span;
	int  n_ok, n_range, n_full, n_at_depth, n_at_empty;
	logic calm_phase;

	// No idling on either side for one stretch out of four
	assign calm_phase = ((cmds_taken / 40) % 4) == 1;

	initial clk = 1'b0;
	always #(HALF_PERIOD) clk = ~clk;

	task automatic report_mismatch(string what, logic [31:0] want, logic [31:0] got);
		mismatch_count++;
		$display("MISMATCH @%0t reply %0d: %s expected 0x%0h got 0x%0h",
			$time, replies_seen, what, want, got);
	endtask

	task automatic queue_cmd(logic [FIELD_CMD_W-1:0] cmd, int index,
			logic [FIELD_VALUE_W-1:0] value, bit wait_idle);
		list_cmd_t it;
		it.cmd       = cmd;
		it.index     = index[FIELD_INDEX_W-1:0];
		it.value     = value;
		it.wait_idle = wait_idle;
		pending_cmds.push_back(it);
	endtask

	// Mostly short gaps, now and then a long one
	function automatic int idle_span();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	// Apply one command to the shadow list and return the response it produces
	function automatic list_reply_t model_list_cmd(logic [FIELD_CMD_W-1:0] cmd,
			logic [FIELD_INDEX_W-1:0] idx, logic [FIELD_VALUE_W-1:0] value);
		list_reply_t r;
		int          pos;
		int          j;
		r.status     = ST_OK;
		r.read_value = '0;
		pos          = int'(idx);
		case (cmd)
			CMD_GET: begin
				if (pos < shadow_count)
					r.read_value = shadow_entries[pos];
				else
					r.status = ST_RANGE;
			end
			CMD_SET: begin
				if (pos < shadow_count)
					shadow_entries[pos] = value;
				else
					r.status = ST_RANGE;
			end
			CMD_INS, CMD_APP: begin
				if (cmd == CMD_APP)
					pos = shadow_count;
				// range is checked ahead of fullness
				if (pos > shadow_count)
					r.status = ST_RANGE;
				else if (shadow_count >= DEPTH)
					r.status = ST_FULL;
				else begin
					for (j = shadow_count; j > pos; j--)
						shadow_entries[j] = shadow_entries[j-1];
					shadow_entries[pos] = value;
					shadow_count++;
				end
			end
			CMD_REM: begin
				if (pos < shadow_count) begin
					r.read_value = shadow_entries[pos];
					for (j = pos; j + 1 < shadow_count; j++)
						shadow_entries[j] = shadow_entries[j+1];
					shadow_count--;
				end else begin
					r.status = ST_RANGE;
				end
			end
			default: begin
			end
		endcase
		r.count     = shadow_count[FIELD_COUNT_W-1:0];
		r.empty_res = (shadow_count == 0);
		return r;
	endfunction

	// Check responses, then record accepted commands
	always @(posedge clk) begin
		if (!arst_n) begin
			cmd_taken_now = 1'b0;
		end else begin
			cmd_taken_now = req_ch.valid && req_ch.ready;
			if (rsp_ch.valid && rsp_ch.ready) begin
				replies_seen++;
				if (list_replies_due.size() == 0) begin
					report_mismatch("response with nothing outstanding", 32'd0, 32'd1);
				end else begin
					list_reply_t due;
					due = list_replies_due.pop_front();
					if (rsp_ch.status !== due.status)
						report_mismatch("status", 32'(due.status), 32'(rsp_ch.status));
					if (rsp_ch.read_value !== due.read_value)
						report_mismatch("read_value", due.read_value, rsp_ch.read_value);
					if (rsp_ch.count !== due.count)
						report_mismatch("count", 32'(due.count), 32'(rsp_ch.count));
					if (rsp_ch.empty_res !== due.empty_res)
						report_mismatch("empty_res", 32'(due.empty_res),
							32'(rsp_ch.empty_res));
					case (due.status)
						ST_OK:    n_ok++;
						ST_RANGE: n_range++;
						default:  n_full++;
					endcase
					if (due.count == DEPTH)
						n_at_depth++;
					if (due.empty_res)
						n_at_empty++;
				end
			end
			if (cmd_taken_now) begin
				list_replies_due.push_back(model_list_cmd(req_ch.cmd, req_ch.index,
					req_ch.value));
				cmds_taken++;
			end
		end
	end

	// Command driver: hold until taken, insert gaps, honor drain points
	always @(negedge clk) begin
		if (!arst_n) begin
			req_ch.valid <= 1'b0;
			req_ch.cmd   <= '0;
			req_ch.index <= '0;
			req_ch.value <= '0;
		end else if (req_ch.valid && !cmd_taken_now) begin
		end else if (send_gap_left > 0 && long_hold_left == 0) begin
			req_ch.valid  <= 1'b0;
			send_gap_left <= send_gap_left - 1;
		end else if (pending_cmds.size() == 0) begin
			req_ch.valid <= 1'b0;
		end else if (pending_cmds[0].wait_idle && list_replies_due.size() != 0) begin
			req_ch.valid <= 1'b0;
		end else begin
			drive_item = pending_cmds.pop_front();
			req_ch.valid  <= 1'b1;
			req_ch.cmd    <= drive_item.cmd;
			req_ch.index  <= drive_item.index;
			req_ch.value  <= drive_item.value;
			send_gap_left <= calm_phase ? 0 : idle_span();
		end
	end

	// Response sink: random stalls plus one long hold-off
	always @(negedge clk) begin
		if (!arst_n) begin
			rsp_ch.ready <= 1'b0;
		end else if (long_hold_left > 0) begin
			rsp_ch.ready   <= 1'b0;
			long_hold_left <= long_hold_left - 1;
		end else if (!long_hold_done && cmds_taken >= LONG_HOLD_AT) begin
			rsp_ch.ready   <= 1'b0;
			long_hold_done <= 1'b1;
			long_hold_left <= LONG_HOLD_CYCLES;
		end else if (rsp_stall_left > 0) begin
			rsp_ch.ready   <= 1'b0;
			rsp_stall_left <= rsp_stall_left - 1;
		end else if (calm_phase) begin
			rsp_ch.ready <= 1'b1;
		end else begin
			span = idle_span();
			rsp_ch.ready   <= (span == 0);
			rsp_stall_left <= (span == 0) ? 0 : span - 1;
		end
	end

	// Build the stimulus, release reset, wait for the list to drain
	initial begin
		int                       k;
		int                       n;
		int                       roll;
		int                       gen_len;
		int                       top;
		bit                       filling;
		list_cmd_t                it;

		arst_n = 1'b0;

		// Errors on an empty list
		queue_cmd(CMD_GET, 0, 32'h0, 1'b1);
		queue_cmd(CMD_REM, 0, 32'h0, 1'b0);
		queue_cmd(CMD_SET, 0, 32'h1234_5678, 1'b0);
		queue_cmd(CMD_INS, 1, 32'hDEAD_BEEF, 1'b0);
		// Fill to capacity with front, middle and tail insertions
		queue_cmd(CMD_INS, 0, '1, 1'b0);
		for (k = 1; k < DEPTH; k++) begin
			case (k % 3)
				0:       queue_cmd(CMD_INS, 0, $urandom, 1'b0);
				1:       queue_cmd(CMD_APP, INDEX_MAX, $urandom, 1'b0);
				default: queue_cmd(CMD_INS, k / 2, $urandom, 1'b0);
			endcase
		end
		// Full list: append and insert refused, range wins over full
		queue_cmd(CMD_APP, 0, 32'hAAAA_5555, 1'b0);
		queue_cmd(CMD_INS, 0, 32'h5555_AAAA, 1'b0);
		queue_cmd(CMD_INS, DEPTH + 1, 32'h0F0F_0F0F, 1'b0);
		queue_cmd(CMD_GET, DEPTH - 1, 32'h0, 1'b0);
		queue_cmd(CMD_GET, DEPTH, 32'h0, 1'b0);
		queue_cmd(CMD_SET, DEPTH - 1, 32'h0, 1'b0);
		// Remove the last entry, then the first
		queue_cmd(CMD_REM, DEPTH - 1, 32'h0, 1'b0);
		queue_cmd(CMD_REM, 0, 32'h0, 1'b0);
		queue_cmd(CMD_GET, INDEX_MAX, 32'h0, 1'b0);
		for (k = int'(CMD_UNUSED_FIRST); k <= int'(CMD_UNUSED_LAST); k++)
			queue_cmd(k[FIELD_CMD_W-1:0], INDEX_MAX, '1, 1'b0);
		// Two removals after the fill leave DEPTH-2 entries
		gen_len = DEPTH - 2;

		// Random pass: alternate fill-heavy and drain-heavy stretches
		for (n = 0; n < RANDOM_CMDS; n++) begin
			filling      = ((n / 60) % 2) == 0;
			roll         = $urandom_range(0, 99);
			it.wait_idle = (n % 150) == 0;
			if (roll < 3)
				it.cmd = FIELD_CMD_W'($urandom_range(CMD_UNUSED_FIRST, CMD_UNUSED_LAST));
			else if (roll < 18)
				it.cmd = CMD_GET;
			else if (roll < 30)
				it.cmd = CMD_SET;
			else if (roll < 80)
				it.cmd = filling ? (roll[0] ? CMD_INS : CMD_APP) : CMD_REM;
			else
				it.cmd = filling ? CMD_REM : (roll[0] ? CMD_INS : CMD_APP);

			// Highest valid index for this command
			top  = (it.cmd == CMD_INS) ? gen_len : gen_len - 1;
			roll = $urandom_range(0, 99);
			if (it.cmd == CMD_APP || it.cmd >= CMD_UNUSED_FIRST)
				it.index = FIELD_INDEX_W'($urandom_range(0, INDEX_MAX));
			else if (top < 0 || roll < 8)
				it.index = FIELD_INDEX_W'($urandom_range(top + 1, INDEX_MAX));
			else if (roll < 25)
				it.index = '0;
			else if (roll < 42)
				it.index = FIELD_INDEX_W'(top);
			else
				it.index = FIELD_INDEX_W'($urandom_range(0, top));

			roll = $urandom_range(0, 99);
			if (roll < 5)
				it.value = '0;
			else if (roll < 10)
				it.value = '1;
			else
				it.value = $urandom;
			pending_cmds.push_back(it);

			// Track the length so indexes stay mostly in range
			case (it.cmd)
				CMD_INS: if (it.index <= gen_len && gen_len < DEPTH) gen_len++;
				CMD_APP: if (gen_len < DEPTH) gen_len++;
				CMD_REM: if (it.index < gen_len) gen_len--;
				default: begin
				end
			endcase
		end
		total_cmds = pending_cmds.size();

		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		while (cmds_taken != total_cmds || list_replies_due.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);

		$display("Ran %0d commands, checked %0d responses: %0d ok, %0d out of range, %0d full.",
			cmds_taken, replies_seen, n_ok, n_range, n_full);
		$display("List seen at capacity %0d times and empty %0d times; %0d mismatches.",
			n_at_depth, n_at_empty, mismatch_count);
		if (mismatch_count == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

	// Watchdog
	initial begin
		#(TIMEOUT_NS);
		$display("Timeout: %0d of %0d commands taken, %0d responses outstanding",
			cmds_taken, total_cmds, list_replies_due.size());
		$display("*** FAILED ***");
		$finish;
	end

endmodule
